/* hw/rtl/atl_pkg.sv */
package atl_pkg;

    localparam int PACKET_BYTES_DEF = 48;
    localparam int RX_BUFFER_BYTES_DEF = 100;
    localparam int WINDOW_LEN = 12;
    localparam int NUM_TEXTS = 6;

    localparam logic [1:0] FUNC_BYTE  = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_CLEAN = 2'd2;
    localparam logic [1:0] FUNC_CLEAR = 2'd3;

    localparam logic [2:0] KIND_STATUS = 3'd0;
    localparam logic [2:0] KIND_PACKET = 3'd1;
    localparam logic [2:0] KIND_DENS   = 3'd2;
    localparam logic [2:0] KIND_READ   = 3'd3;
    localparam logic [2:0] KIND_CMD    = 3'd4;

    localparam logic [2:0] CMD_NONE   = 3'd0;
    localparam logic [2:0] CMD_ENTER  = 3'd1;
    localparam logic [2:0] CMD_STOFF  = 3'd2;
    localparam logic [2:0] CMD_QSTAT  = 3'd3;
    localparam logic [2:0] CMD_QNAME  = 3'd4;
    localparam logic [2:0] CMD_SNAME  = 3'd5;
    localparam logic [2:0] CMD_EXIT   = 3'd6;

    localparam logic [3:0] STEP_DONE  = 4'd13;
    localparam logic [3:0] STEP_RESET = 4'd14;

    localparam int TXT_OK = 0;
    localparam int TXT_ERROR = 1;
    localparam int TXT_NAME = 2;
    localparam int TXT_STAT0 = 3;
    localparam int TXT_CONN = 4;
    localparam int TXT_DEVERR = 5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SINGLE,
        ST_RUN
    } state_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic exec;      // apply the held item
        logic run_start; // reset the run read index
        logic run_step;  // advance the run read index
    } dp_cmd_t;

    typedef struct packed {
        logic run_item;  // executed item produces a packet run
        logic run_final; // read index is at the final packet byte
    } dp_status_t;

    function automatic logic [7:0] text_len(input int t);
        case (t)
            0: text_len = 8'd4;
            1: text_len = 8'd7;
            2: text_len = 8'd8;
            3: text_len = 8'd11;
            4: text_len = 8'd9;
            default: text_len = 8'd12;
        endcase
    endfunction

    // Text character i (left aligned).
    function automatic logic [7:0] text_chr(input int t, input int i);
        logic [95:0] s;
        s = '0;
        case (t)
            0: s = {8'h4F, 8'h4B, 8'h0D, 8'h0A, 64'h0};
            1: s = {"ERROR", 8'h0D, 8'h0A, 40'h0};
            2: s = {8'h52, 8'h46, 8'h2D, 8'h43, 8'h52, 8'h41, 8'h5A, 8'h59, 32'h0};
            3: s = {"AT+STATUS=0", 8'h0};
            4: s = {"CONNECTED", 24'h0};
            default: s = "DEVICE ERROR";
        endcase
        text_chr = s[95 - 8 * i -: 8];
    endfunction

endpackage

/* hw/rtl/atl_ctrl.sv */
module atl_ctrl
    import atl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic       load,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        load = 1'b0;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    load = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                cmd.run_start = 1'b1;
                state_next = status.run_item ? ST_RUN : ST_SINGLE;
            end
            ST_SINGLE: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RUN: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd.run_step = 1'b1;
                    if (status.run_final) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* hw/rtl/atl_datapath.sv */
module atl_datapath
    import atl_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    parameter int RX_BUFFER_BYTES = RX_BUFFER_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  logic [1:0]  in_func,
    input  logic [7:0]  in_byte,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    output logic [2:0]  kind,
    output logic [7:0]  data_byte,
    output logic        last,
    output logic [2:0]  at_command,
    output logic [6:0]  heat_density,
    output logic [3:0]  setup_step,
    output logic [31:0] packet_count,
    output logic        clean_pending,
    output logic        reboot_needed,
    output logic        setup_done
);

    localparam int IW = $clog2(RX_BUFFER_BYTES + 1);
    localparam int PW = $clog2(PACKET_BYTES);

    logic [1:0]  func_reg;
    logic [7:0]  byte_reg;
    logic [3:0]  step_reg, step_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [7:0]  win_reg [WINDOW_LEN];
    logic [7:0]  win_next [WINDOW_LEN];
    logic [NUM_TEXTS-1:0] seen_reg, seen_next;
    logic        zero_reg, zero_next;
    logic        clean_reg, clean_next;
    logic        reboot_reg, reboot_next;
    logic [31:0] count_reg, count_next;
    logic [7:0]  store [PACKET_BYTES];
    logic [7:0]  head_reg [4];
    logic [2:0]  kind_reg, kind_next;
    logic [2:0]  atc_reg, atc_next;
    logic [6:0]  dens_reg, dens_next;
    logic [PW-1:0] ridx_reg;
    logic [7:0]  rdata_reg;
    logic        run_next;
    logic        wr_en;
    logic [NUM_TEXTS-1:0] hit;
    logic        blocked;
    logic        clr;
    logic        all_a5, all_a6;

    always_ff @(posedge aclk) begin
        if (load) begin
            func_reg <= in_func;
            byte_reg <= in_byte;
        end
        if (wr_en) begin
            store[idx_reg[PW-1:0]] <= byte_reg;
            if (idx_reg < IW'(4)) begin
                head_reg[idx_reg[1:0]] <= byte_reg;
            end
        end
        if (cmd.run_start) begin
            ridx_reg <= '0;
            rdata_reg <= store[0];
        end else if (cmd.run_step) begin
            ridx_reg <= ridx_reg + PW'(1);
            rdata_reg <= store[(ridx_reg == PW'(PACKET_BYTES - 1)) ? '0 : ridx_reg + PW'(1)];
        end
    end

    assign wr_en = cmd.exec && func_reg == FUNC_BYTE && step_reg == STEP_DONE
                   && idx_reg < IW'(PACKET_BYTES);

    // Window after shifting in the held byte, and text matching.
    always_comb begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
            win_next[i] = win_reg[i + 1];
        end
        win_next[WINDOW_LEN - 1] = byte_reg;
        blocked = zero_reg || byte_reg == 8'h00;
        for (int t = 0; t < NUM_TEXTS; t++) begin
            hit[t] = 1'b1;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                if (i < int'(text_len(t)) &&
                    win_next[WINDOW_LEN - int'(text_len(t)) + i] != text_chr(t, i)) begin
                    hit[t] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        // First four bytes of the current packet; the fifth is the held byte.
        all_a5 = 1'b1;
        all_a6 = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if (head_reg[k] != 8'hA5) all_a5 = 1'b0;
            if (head_reg[k] != 8'hA6) all_a6 = 1'b0;
        end
    end

    always_comb begin
        logic [NUM_TEXTS-1:0] s;
        logic [IW-1:0] ni;
        step_next = step_reg;
        idx_next = idx_reg;
        seen_next = seen_reg;
        zero_next = zero_reg;
        clean_next = clean_reg;
        reboot_next = reboot_reg;
        count_next = count_reg;
        kind_next = KIND_STATUS;
        atc_next = CMD_NONE;
        dens_next = '0;
        run_next = 1'b0;
        clr = 1'b0;
        s = blocked ? seen_reg : (seen_reg | hit);
        ni = idx_reg + IW'(1);
        case (func_reg)
            FUNC_TICK: begin
                kind_next = KIND_CMD;
                case (step_reg)
                    4'd0, 4'd1: begin step_next = 4'd1; atc_next = CMD_ENTER; end
                    4'd2, 4'd3: begin step_next = 4'd3; atc_next = CMD_STOFF; end
                    4'd4, 4'd5: begin step_next = 4'd5; atc_next = CMD_QSTAT; end
                    4'd6, 4'd7: begin step_next = 4'd7; atc_next = CMD_QNAME; end
                    4'd8, 4'd10: begin
                        step_next = 4'd10;
                        atc_next = CMD_SNAME;
                        reboot_next = 1'b1;
                    end
                    4'd9, 4'd11, 4'd12: begin step_next = 4'd12; atc_next = CMD_EXIT; end
                    STEP_RESET: atc_next = CMD_EXIT;
                    default: kind_next = KIND_STATUS;
                endcase
            end
            FUNC_CLEAN: begin
                if (clean_reg) begin
                    clr = 1'b1;
                    clean_next = 1'b0;
                end
            end
            FUNC_CLEAR: count_next = '0;
            default: begin
                idx_next = ni;
                zero_next = zero_reg || byte_reg == 8'h00;
                seen_next = s;
                if (step_reg != STEP_DONE) begin
                    if (s[TXT_OK]) begin
                        case (step_reg)
                            4'd1: step_next = 4'd2;
                            4'd3: step_next = 4'd4;
                            4'd7: step_next = s[TXT_NAME] ? 4'd8 : 4'd9;
                            4'd10: step_next = 4'd11;
                            4'd12: step_next = STEP_DONE;
                            STEP_RESET: step_next = 4'd0;
                            4'd5: step_next = s[TXT_STAT0] ? 4'd6 : 4'd3;
                            default: step_next = step_reg;
                        endcase
                        clr = 1'b1;
                    end else begin
                        if (s[TXT_ERROR]) step_next = STEP_RESET;
                        if (ni >= IW'(RX_BUFFER_BYTES)) idx_next = '0;
                    end
                end else begin
                    if (s[TXT_CONN] || s[TXT_DEVERR]) clean_next = 1'b1;
                    if (ni == IW'(5) && all_a5) begin
                        kind_next = KIND_DENS;
                        dens_next = (byte_reg == 8'd1) ? 7'd30 :
                                    (byte_reg == 8'd2) ? 7'd60 : 7'd100;
                        clr = 1'b1;
                    end else if (ni == IW'(5) && all_a6) begin
                        kind_next = KIND_READ;
                        clr = 1'b1;
                    end else if (ni >= IW'(PACKET_BYTES)) begin
                        kind_next = KIND_PACKET;
                        count_next = count_reg + 32'd1;
                        run_next = 1'b1;
                        clr = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            idx_reg <= '0;
            seen_reg <= '0;
            zero_reg <= 1'b0;
            clean_reg <= 1'b0;
            reboot_reg <= 1'b0;
            count_reg <= '0;
            for (int i = 0; i < WINDOW_LEN; i++) win_reg[i] <= '0;
        end else if (cmd.exec) begin
            step_reg <= step_next;
            clean_reg <= clean_next;
            reboot_reg <= reboot_next;
            count_reg <= count_next;
            if (clr) begin
                idx_reg <= '0;
                seen_reg <= '0;
                zero_reg <= 1'b0;
                for (int i = 0; i < WINDOW_LEN; i++) win_reg[i] <= '0;
            end else begin
                idx_reg <= idx_next;
                seen_reg <= seen_next;
                zero_reg <= zero_next;
                if (func_reg == FUNC_BYTE) begin
                    for (int i = 0; i < WINDOW_LEN; i++) win_reg[i] <= win_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            kind_reg <= kind_next;
            atc_reg <= atc_next;
            dens_reg <= dens_next;
        end
    end

    assign status.run_item = run_next;
    assign status.run_final = ridx_reg == PW'(PACKET_BYTES - 1);

    assign kind = kind_reg;
    assign data_byte = (kind_reg == KIND_PACKET) ? rdata_reg : 8'h00;
    assign last = kind_reg == KIND_PACKET && status.run_final;
    assign at_command = atc_reg;
    assign heat_density = dens_reg;
    assign setup_step = step_reg;
    assign packet_count = count_reg;
    assign clean_pending = clean_reg;
    assign reboot_needed = reboot_reg;
    assign setup_done = step_reg == STEP_DONE;

endmodule

/* hw/rtl/at_link_setup_and_packet_deframer.sv */
// AT link setup sequencer and print-packet deframer. Each input transaction
// (func in bits 1:0 of s_tdata, received byte in bits 9:2) is taken when the
// block is idle, executed in the EXEC state and answered with one result
// transaction, or with PACKET_BYTES result transactions when a received byte
// completes a print packet; the run ends with m_tlast. A packet run reads the
// packet store one entry a cycle while m_tready is high, and a new input is
// taken only after the last result transaction is accepted.
// The packet store has no reset; only entries written since the last clear
// are ever read.
module at_link_setup_and_packet_deframer
    import atl_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    parameter int RX_BUFFER_BYTES = RX_BUFFER_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // func[1:0], rx_byte[9:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // kind[2:0], data_byte[10:3], at_command[13:11],
                                  // heat_density[20:14], setup_step[24:21],
                                  // packet_count[56:25], clean_pending[57],
                                  // reboot_needed[58], setup_done[59]
    output logic        m_tlast
);

    logic       load;
    dp_cmd_t    cmd;
    dp_status_t status;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [2:0]  at_command;
    logic [6:0]  heat_density;
    logic [3:0]  setup_step;
    logic [31:0] packet_count;
    logic        clean_pending, reboot_needed, setup_done;

    atl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .load    (load),
        .cmd     (cmd),
        .status  (status)
    );

    atl_datapath #(
        .PACKET_BYTES   (PACKET_BYTES),
        .RX_BUFFER_BYTES(RX_BUFFER_BYTES)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (load),
        .in_func      (s_tdata[1:0]),
        .in_byte      (s_tdata[9:2]),
        .cmd          (cmd),
        .status       (status),
        .kind         (kind),
        .data_byte    (data_byte),
        .last         (m_tlast),
        .at_command   (at_command),
        .heat_density (heat_density),
        .setup_step   (setup_step),
        .packet_count (packet_count),
        .clean_pending(clean_pending),
        .reboot_needed(reboot_needed),
        .setup_done   (setup_done)
    );

    assign m_tdata = {4'b0, setup_done, reboot_needed, clean_pending, packet_count,
                      setup_step, heat_density, at_command, data_byte, kind};

endmodule
